// ===== hdl/vplc_pkg.sv =====
// Shared fourcc codes, format descriptor and layout result types.
`default_nettype none
package vplc_pkg;

  // fourcc codes, first character in the low byte
  localparam logic [31:0] FCC_NV12 = 32'h3231564E;
  localparam logic [31:0] FCC_P010 = 32'h30313050;
  localparam logic [31:0] FCC_I420 = 32'h30323449;
  localparam logic [31:0] FCC_YV12 = 32'h32315659;
  localparam logic [31:0] FCC_IMC3 = 32'h33434D49;
  localparam logic [31:0] FCC_422H = 32'h48323234;
  localparam logic [31:0] FCC_422V = 32'h56323234;
  localparam logic [31:0] FCC_444P = 32'h50343434;
  localparam logic [31:0] FCC_YUY2 = 32'h32595559;
  localparam logic [31:0] FCC_UYVY = 32'h59565955;
  localparam logic [31:0] FCC_RGBX = 32'h58424752;
  localparam logic [31:0] FCC_RGBA = 32'h41424752;
  localparam logic [31:0] FCC_BGRX = 32'h58524742;
  localparam logic [31:0] FCC_BGRA = 32'h41524742;

  localparam int PITCH_W  = 16;
  localparam int ROWS_W   = 14;
  localparam int OFFSET_W = 30;

  // Decoded format: table formats use wmul/hmul, semi-planar ones use semi/wide.
  typedef struct packed {
    logic       ok;
    logic [1:0] planes;
    logic       semi;
    logic       wide;
    logic [3:0] wmul0;
    logic [3:0] wmul1;
    logic [3:0] wmul2;
    logic [1:0] hmul0;
    logic [1:0] hmul1;
    logic [1:0] hmul2;
  } fmt_info_t;

  typedef struct packed {
    logic                ok;
    logic [1:0]          plane_count;
    logic [PITCH_W-1:0]  pitch_zero;
    logic [ROWS_W-1:0]   rows_zero;
    logic [PITCH_W-1:0]  pitch_one;
    logic [ROWS_W-1:0]   rows_one;
    logic [PITCH_W-1:0]  pitch_two;
    logic [ROWS_W-1:0]   rows_two;
    logic [OFFSET_W-1:0] offset_one;
    logic [OFFSET_W-1:0] offset_two;
  } layout_t;

endpackage
`default_nettype wire

// ===== hdl/vplc_if.sv =====
// Valid/ready channel interfaces for frame requests and layout results.
`default_nettype none
interface vplc_in_if #(
  parameter int DIM_BITS = 14
);
  logic                valid;
  logic                ready;
  logic [31:0]         format_code;
  logic [DIM_BITS-1:0] pixel_width;
  logic [DIM_BITS-1:0] pixel_height;

  modport source (output valid, output format_code, output pixel_width,
                  output pixel_height, input ready);
  modport sink   (input valid, input format_code, input pixel_width,
                  input pixel_height, output ready);
endinterface

interface vplc_out_if;
  logic                           valid;
  logic                           ready;
  logic                           ok;
  logic [1:0]                     plane_count;
  logic [vplc_pkg::PITCH_W-1:0]  pitch_zero;
  logic [vplc_pkg::ROWS_W-1:0]   rows_zero;
  logic [vplc_pkg::PITCH_W-1:0]  pitch_one;
  logic [vplc_pkg::ROWS_W-1:0]   rows_one;
  logic [vplc_pkg::PITCH_W-1:0]  pitch_two;
  logic [vplc_pkg::ROWS_W-1:0]   rows_two;
  logic [vplc_pkg::OFFSET_W-1:0] offset_one;
  logic [vplc_pkg::OFFSET_W-1:0] offset_two;

  modport source (output valid, output ok, output plane_count, output pitch_zero,
                  output rows_zero, output pitch_one, output rows_one,
                  output pitch_two, output rows_two, output offset_one,
                  output offset_two, input ready);
  modport sink   (input valid, input ok, input plane_count, input pitch_zero,
                  input rows_zero, input pitch_one, input rows_one,
                  input pitch_two, input rows_two, input offset_one,
                  input offset_two, output ready);
endinterface
`default_nettype wire

// ===== hdl/video_plane_layout_calculator.sv =====
// Top level: input register, single-pass layout logic and result register.
//
// Computes the memory layout of a video frame from its fourcc and size: plane
// count, and per plane the pitch in bytes, the row count and the byte offset
// from the frame start. NV12 and P010 are semi-planar; twelve more planar and
// packed formats come from a fixed format table; any other code returns all
// zeros with ok clear. One transaction is accepted every cycle while results are
// taken, and each request is held in the input register, then the format decode,
// shifts and the two pitch-times-rows multipliers feeding the offsets settle
// into the result register. Both stages hold under backpressure, and the input
// side keeps accepting while a result waits as long as the input register is
// empty.
`default_nettype none
module video_plane_layout_calculator #(
  parameter int DIM_BITS = 14
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  vplc_in_if.sink    in_if,
  vplc_out_if.source out_if
);

  logic                 in_valid_r;
  logic [31:0]          in_code_r;
  logic [DIM_BITS-1:0]  in_w_r;
  logic [DIM_BITS-1:0]  in_h_r;
  logic                 out_valid_r;
  vplc_pkg::layout_t    res_r;
  vplc_pkg::layout_t    res_nxt;
  vplc_pkg::fmt_info_t  info;
  logic                 out_load;
  logic                 in_load;

  // advance each stage when its successor is free or draining
  assign out_load    = !out_valid_r || out_if.ready;
  assign in_load     = !in_valid_r || out_load;
  assign in_if.ready = in_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_load) begin
        in_valid_r <= in_if.valid;
      end
      if (out_load) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_load && in_if.valid) begin
      in_code_r <= in_if.format_code;
      in_w_r    <= in_if.pixel_width;
      in_h_r    <= in_if.pixel_height;
    end
    if (out_load && in_valid_r) begin
      res_r <= res_nxt;
    end
  end

  vplc_fmt_decode u_decode (
    .code (in_code_r),
    .info (info)
  );

  vplc_layout #(
    .DIM_BITS (DIM_BITS)
  ) u_layout (
    .info (info),
    .w    (in_w_r),
    .h    (in_h_r),
    .res  (res_nxt)
  );

  assign out_if.valid       = out_valid_r;
  assign out_if.ok          = res_r.ok;
  assign out_if.plane_count = res_r.plane_count;
  assign out_if.pitch_zero  = res_r.pitch_zero;
  assign out_if.rows_zero   = res_r.rows_zero;
  assign out_if.pitch_one   = res_r.pitch_one;
  assign out_if.rows_one    = res_r.rows_one;
  assign out_if.pitch_two   = res_r.pitch_two;
  assign out_if.rows_two    = res_r.rows_two;
  assign out_if.offset_one  = res_r.offset_one;
  assign out_if.offset_two  = res_r.offset_two;

endmodule
`default_nettype wire

// ===== hdl/vplc_fmt_decode.sv =====
// Fourcc decoder: maps a format code to its plane count and size multipliers.
`default_nettype none
module vplc_fmt_decode (
  input  wire logic [31:0]         code,
  output vplc_pkg::fmt_info_t      info
);

  always_comb begin
    info = '0;
    unique case (code) inside
      vplc_pkg::FCC_NV12: begin
        info.ok     = 1'b1;
        info.planes = 2'd2;
        info.semi   = 1'b1;
      end
      vplc_pkg::FCC_P010: begin
        info.ok     = 1'b1;
        info.planes = 2'd2;
        info.semi   = 1'b1;
        info.wide   = 1'b1;
      end
      vplc_pkg::FCC_I420, vplc_pkg::FCC_YV12, vplc_pkg::FCC_IMC3: begin
        info.ok     = 1'b1;
        info.planes = 2'd3;
        info.wmul0  = 4'd2;
        info.wmul1  = 4'd1;
        info.wmul2  = 4'd1;
        info.hmul0  = 2'd2;
        info.hmul1  = 2'd1;
        info.hmul2  = 2'd1;
      end
      vplc_pkg::FCC_422H: begin
        info.ok     = 1'b1;
        info.planes = 2'd3;
        info.wmul0  = 4'd2;
        info.wmul1  = 4'd1;
        info.wmul2  = 4'd1;
        info.hmul0  = 2'd2;
        info.hmul1  = 2'd2;
        info.hmul2  = 2'd2;
      end
      vplc_pkg::FCC_422V: begin
        info.ok     = 1'b1;
        info.planes = 2'd3;
        info.wmul0  = 4'd2;
        info.wmul1  = 4'd2;
        info.wmul2  = 4'd2;
        info.hmul0  = 2'd2;
        info.hmul1  = 2'd1;
        info.hmul2  = 2'd1;
      end
      vplc_pkg::FCC_444P: begin
        info.ok     = 1'b1;
        info.planes = 2'd3;
        info.wmul0  = 4'd2;
        info.wmul1  = 4'd2;
        info.wmul2  = 4'd2;
        info.hmul0  = 2'd2;
        info.hmul1  = 2'd2;
        info.hmul2  = 2'd2;
      end
      vplc_pkg::FCC_YUY2, vplc_pkg::FCC_UYVY: begin
        info.ok     = 1'b1;
        info.planes = 2'd1;
        info.wmul0  = 4'd4;
        info.hmul0  = 2'd2;
      end
      vplc_pkg::FCC_RGBX, vplc_pkg::FCC_RGBA, vplc_pkg::FCC_BGRX, vplc_pkg::FCC_BGRA: begin
        info.ok     = 1'b1;
        info.planes = 2'd1;
        info.wmul0  = 4'd8;
        info.hmul0  = 2'd2;
      end
      default: begin
        info = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/vplc_layout.sv =====
// Plane geometry: pitches, row counts and packed plane offsets.
`default_nettype none
module vplc_layout #(
  parameter int DIM_BITS = 14
) (
  input  wire vplc_pkg::fmt_info_t  info,
  input  wire logic [DIM_BITS-1:0]  w,
  input  wire logic [DIM_BITS-1:0]  h,
  output vplc_pkg::layout_t         res
);

  localparam int PW  = DIM_BITS + 2;   // widest pitch is 4*w
  localparam int MW  = DIM_BITS + 4;   // w*8 + 1
  localparam int HW  = DIM_BITS + 2;   // h*2 + 1
  localparam int PRW = PW + DIM_BITS;
  localparam int OW  = vplc_pkg::OFFSET_W;
  localparam int PTW = vplc_pkg::PITCH_W;
  localparam int RW  = vplc_pkg::ROWS_W;

  logic [MW-1:0]       tw0, tw1, tw2;
  logic [HW-1:0]       th0, th1, th2;
  logic [DIM_BITS:0]   w_even;
  logic [DIM_BITS:0]   h_up;
  logic [PW-1:0]       sp0, sp1;
  logic [PW-1:0]       p0, p1, p2;
  logic [DIM_BITS-1:0] r0, r1, r2;
  logic [PRW-1:0]      prod0, prod1;
  logic [PRW+OW-1:0]   pe0, pe1;
  logic [OW:0]         sum2;
  logic [PW+PTW-1:0]   px0, px1, px2;
  logic [DIM_BITS+RW-1:0] rx0, rx1, rx2;

  // table formats: (len * mult + 1) >> 1
  assign tw0 = MW'(w) * MW'(info.wmul0) + MW'(1);
  assign tw1 = MW'(w) * MW'(info.wmul1) + MW'(1);
  assign tw2 = MW'(w) * MW'(info.wmul2) + MW'(1);
  assign th0 = HW'(h) * HW'(info.hmul0) + HW'(1);
  assign th1 = HW'(h) * HW'(info.hmul1) + HW'(1);
  assign th2 = HW'(h) * HW'(info.hmul2) + HW'(1);

  // semi-planar: chroma pitch rounded to even, chroma rows ceil(h/2), P010 doubles
  assign w_even = {1'b0, w} + {{DIM_BITS{1'b0}}, w[0]};
  assign h_up   = {1'b0, h} + {{DIM_BITS{1'b0}}, 1'b1};
  assign sp0    = info.wide ? {1'b0, w, 1'b0} : {2'b00, w};
  assign sp1    = info.wide ? {w_even, 1'b0} : {1'b0, w_even};

  always_comb begin
    if (info.semi) begin
      p0 = sp0;
      r0 = h;
      p1 = sp1;
      r1 = h_up[DIM_BITS:1];
      p2 = '0;
      r2 = '0;
    end else begin
      p0 = tw0[PW:1];
      r0 = th0[DIM_BITS:1];
      p1 = tw1[PW:1];
      r1 = th1[DIM_BITS:1];
      p2 = tw2[PW:1];
      r2 = th2[DIM_BITS:1];
    end
  end

  assign prod0 = PRW'(p0) * PRW'(r0);
  assign prod1 = PRW'(p1) * PRW'(r1);
  assign pe0   = {{OW{1'b0}}, prod0};
  assign pe1   = {{OW{1'b0}}, prod1};
  assign sum2  = {1'b0, pe0[OW-1:0]} + {1'b0, pe1[OW-1:0]};

  assign px0 = {{PTW{1'b0}}, p0};
  assign px1 = {{PTW{1'b0}}, p1};
  assign px2 = {{PTW{1'b0}}, p2};
  assign rx0 = {{RW{1'b0}}, r0};
  assign rx1 = {{RW{1'b0}}, r1};
  assign rx2 = {{RW{1'b0}}, r2};

  always_comb begin
    res             = '0;
    res.ok          = info.ok;
    res.plane_count = info.planes;
    res.pitch_zero  = px0[PTW-1:0];
    res.rows_zero   = rx0[RW-1:0];
    res.pitch_one   = px1[PTW-1:0];
    res.rows_one    = rx1[RW-1:0];
    res.pitch_two   = px2[PTW-1:0];
    res.rows_two    = rx2[RW-1:0];
    if (info.planes > 2'd1) begin
      res.offset_one = pe0[OW-1:0];
    end
    if (info.planes > 2'd2) begin
      res.offset_two = sum2[OW-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== tb/tb_video_plane_layout_calculator.sv =====
// Self-checking testbench for the video plane layout calculator.
`timescale 1ns / 1ps
`default_nettype none
module tb_video_plane_layout_calculator;

  localparam int          DIM_BITS     = 14;
  localparam int          STALL_CYCLES = 300;
  localparam int          IDLE_LIMIT   = 2000;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          RANDOM_ITEMS = 1500;
  localparam int          PITCH_W      = vplc_pkg::PITCH_W;
  localparam int          ROWS_W       = vplc_pkg::ROWS_W;
  localparam int          OFFSET_W     = vplc_pkg::OFFSET_W;
  localparam logic [31:0] KNOWN_CODES [14] = '{
    vplc_pkg::FCC_NV12, vplc_pkg::FCC_P010, vplc_pkg::FCC_I420, vplc_pkg::FCC_YV12,
    vplc_pkg::FCC_IMC3, vplc_pkg::FCC_422H, vplc_pkg::FCC_422V, vplc_pkg::FCC_444P,
    vplc_pkg::FCC_YUY2, vplc_pkg::FCC_UYVY, vplc_pkg::FCC_RGBX, vplc_pkg::FCC_RGBA,
    vplc_pkg::FCC_BGRX, vplc_pkg::FCC_BGRA
  };

  // Holds pending layouts in arrival order and compares each result field by field.
  class layout_scoreboard;
    vplc_pkg::layout_t expected_q[$];
    int unsigned       mismatches;
    int unsigned       unexpected;
    int unsigned       checked;

    function new();
      mismatches = 0;
      unexpected = 0;
      checked    = 0;
    endfunction

    function vplc_pkg::layout_t predict_layout(logic [31:0] code, logic [DIM_BITS-1:0] w,
                                               logic [DIM_BITS-1:0] h);
      vplc_pkg::layout_t res;
      longint unsigned  wl;
      longint unsigned  hl;
      longint unsigned  scale;
      longint unsigned  pitch [3];
      longint unsigned  rows [3];
      longint unsigned  wm [3];
      longint unsigned  hm [3];
      longint unsigned  off1;
      longint unsigned  off2;
      int unsigned      planes;
      bit               known;
      res    = '0;
      wl     = w;
      hl     = h;
      pitch  = '{0, 0, 0};
      rows   = '{0, 0, 0};
      wm     = '{0, 0, 0};
      hm     = '{0, 0, 0};
      planes = 0;
      known  = 1'b1;
      if (code == vplc_pkg::FCC_NV12 || code == vplc_pkg::FCC_P010) begin
        scale    = (code == vplc_pkg::FCC_P010) ? 2 : 1;
        pitch[0] = wl * scale;
        rows[0]  = hl;
        pitch[1] = (wl + (wl & 1)) * scale;
        rows[1]  = (hl + 1) >> 1;
        planes   = 2;
      end else begin
        case (code)
          vplc_pkg::FCC_I420, vplc_pkg::FCC_YV12, vplc_pkg::FCC_IMC3: begin
            planes = 3; wm = '{2, 1, 1}; hm = '{2, 1, 1};
          end
          vplc_pkg::FCC_422H: begin
            planes = 3; wm = '{2, 1, 1}; hm = '{2, 2, 2};
          end
          vplc_pkg::FCC_422V: begin
            planes = 3; wm = '{2, 2, 2}; hm = '{2, 1, 1};
          end
          vplc_pkg::FCC_444P: begin
            planes = 3; wm = '{2, 2, 2}; hm = '{2, 2, 2};
          end
          vplc_pkg::FCC_YUY2, vplc_pkg::FCC_UYVY: begin
            planes = 1; wm = '{4, 0, 0}; hm = '{2, 0, 0};
          end
          vplc_pkg::FCC_RGBX, vplc_pkg::FCC_RGBA,
          vplc_pkg::FCC_BGRX, vplc_pkg::FCC_BGRA: begin
            planes = 1; wm = '{8, 0, 0}; hm = '{2, 0, 0};
          end
          default: known = 1'b0;
        endcase
        for (int p = 0; p < 3; p++) begin
          if (p < planes) begin
            pitch[p] = (wl * wm[p] + 1) >> 1;
            rows[p]  = (hl * hm[p] + 1) >> 1;
          end
        end
      end
      off1 = (planes > 1) ? pitch[0] * rows[0] : 0;
      off2 = (planes > 2) ? off1 + pitch[1] * rows[1] : 0;
      res.ok          = known;
      res.plane_count = 2'(planes);
      res.pitch_zero  = PITCH_W'(pitch[0]);
      res.rows_zero   = ROWS_W'(rows[0]);
      res.pitch_one   = PITCH_W'(pitch[1]);
      res.rows_one    = ROWS_W'(rows[1]);
      res.pitch_two   = PITCH_W'(pitch[2]);
      res.rows_two    = ROWS_W'(rows[2]);
      res.offset_one  = OFFSET_W'(off1);
      res.offset_two  = OFFSET_W'(off2);
      return res;
    endfunction

    function void note_request(logic [31:0] code, logic [DIM_BITS-1:0] w,
                               logic [DIM_BITS-1:0] h);
      expected_q.push_back(predict_layout(code, w, h));
    endfunction

    function bit field_ok(string name, longint unsigned exp_v, longint unsigned act_v);
      if (exp_v == act_v) return 1'b1;
      if (mismatches < 10)
        $display("%0t: %s mismatch in result %0d: expected %0d, got %0d",
                 $realtime, name, checked, exp_v, act_v);
      return 1'b0;
    endfunction

    function void check_result(vplc_pkg::layout_t got);
      vplc_pkg::layout_t exp_l;
      bit                good;
      if (expected_q.size() == 0) begin
        if (mismatches + unexpected < 10)
          $display("%0t: result with no pending request", $realtime);
        unexpected++;
        return;
      end
      exp_l = expected_q.pop_front();
      good  = 1'b1;
      good &= field_ok("ok", exp_l.ok, got.ok);
      good &= field_ok("plane_count", exp_l.plane_count, got.plane_count);
      good &= field_ok("pitch_zero", exp_l.pitch_zero, got.pitch_zero);
      good &= field_ok("rows_zero", exp_l.rows_zero, got.rows_zero);
      good &= field_ok("pitch_one", exp_l.pitch_one, got.pitch_one);
      good &= field_ok("rows_one", exp_l.rows_one, got.rows_one);
      good &= field_ok("pitch_two", exp_l.pitch_two, got.pitch_two);
      good &= field_ok("rows_two", exp_l.rows_two, got.rows_two);
      good &= field_ok("offset_one", exp_l.offset_one, got.offset_one);
      good &= field_ok("offset_two", exp_l.offset_two, got.offset_two);
      if (!good) mismatches++;
      checked++;
    endfunction
  endclass

  logic clk;
  logic rst_n;

  vplc_in_if #(.DIM_BITS(DIM_BITS)) in_ch ();
  vplc_out_if                       out_ch ();

  video_plane_layout_calculator #(
    .DIM_BITS(DIM_BITS)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  layout_scoreboard layout_sb;
  bit               src_idle;
  bit               sink_idle;
  bit               stall_req;
  int unsigned      idle_count;
  int unsigned      sent_count;
  int unsigned      unknown_count;

  initial begin
    clk = 1'b0;
  end

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [DIM_BITS-1:0] pick_dim();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      case ($urandom_range(0, 4))
        0:       return '0;
        1:       return DIM_BITS'(1);
        2:       return DIM_BITS'(2);
        3:       return '1 - DIM_BITS'(1);
        default: return '1;
      endcase
    end
    if (r < 55) return DIM_BITS'($urandom_range(0, 64));
    return DIM_BITS'($urandom_range(0, (1 << DIM_BITS) - 1));
  endfunction

  task automatic send_request(logic [31:0] code, logic [DIM_BITS-1:0] w,
                              logic [DIM_BITS-1:0] h);
    int unsigned       gap;
    vplc_pkg::layout_t pred;
    gap = src_idle ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.format_code  <= code;
    in_ch.pixel_width  <= w;
    in_ch.pixel_height <= h;
    do @(posedge clk); while (!in_ch.ready);
    layout_sb.note_request(code, w, h);
    sent_count++;
    pred = layout_sb.predict_layout(code, w, h);
    if (pred.ok == 1'b0) unknown_count++;
  endtask

  task automatic send_random_request();
    int unsigned r;
    logic [31:0] code;
    r    = $urandom_range(0, 99);
    code = KNOWN_CODES[$urandom_range(0, 13)];
    if (r >= 90) code = $urandom();
    else if (r >= 80) code = code ^ (32'h1 << $urandom_range(0, 31));
    send_request(code, pick_dim(), pick_dim());
  endtask

  task automatic wait_drained();
    while (layout_sb.expected_q.size() != 0) @(posedge clk);
  endtask

  // Receiver: random backpressure, or one long hold-off when asked.
  initial begin
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (stall_req) begin
        out_ch.ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
        stall_req = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (sink_idle) begin
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Check every result transaction.
  always @(posedge clk) begin
    vplc_pkg::layout_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.ok          = out_ch.ok;
      got.plane_count = out_ch.plane_count;
      got.pitch_zero  = out_ch.pitch_zero;
      got.rows_zero   = out_ch.rows_zero;
      got.pitch_one   = out_ch.pitch_one;
      got.rows_one    = out_ch.rows_one;
      got.pitch_two   = out_ch.pitch_two;
      got.rows_two    = out_ch.rows_two;
      got.offset_one  = out_ch.offset_one;
      got.offset_two  = out_ch.offset_two;
      layout_sb.check_result(got);
    end
  end

  // Watchdog: end the run if no transaction moves on either side for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
      if (idle_count >= IDLE_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    layout_sb          = new();
    src_idle           = 1'b0;
    sink_idle          = 1'b0;
    stall_req          = 1'b0;
    idle_count         = 0;
    sent_count         = 0;
    unknown_count      = 0;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.format_code  = '0;
    in_ch.pixel_width  = '0;
    in_ch.pixel_height = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every format, size extremes, zero size, odd sizes, unknown codes.
    send_request(vplc_pkg::FCC_NV12, '1, '1);
    send_request(vplc_pkg::FCC_NV12, DIM_BITS'(1), DIM_BITS'(1));
    send_request(vplc_pkg::FCC_P010, '1, '1);
    send_request(vplc_pkg::FCC_P010, '0, DIM_BITS'(5));
    send_request(vplc_pkg::FCC_P010, DIM_BITS'(7), '0);
    send_request(vplc_pkg::FCC_I420, '1, '1);
    send_request(vplc_pkg::FCC_YV12, DIM_BITS'(3), DIM_BITS'(5));
    send_request(vplc_pkg::FCC_IMC3, '1 - DIM_BITS'(1), '1);
    send_request(vplc_pkg::FCC_422H, '1, DIM_BITS'(1));
    send_request(vplc_pkg::FCC_422V, DIM_BITS'(1), '1);
    send_request(vplc_pkg::FCC_444P, '1, '1);
    send_request(vplc_pkg::FCC_444P, '0, '0);
    send_request(vplc_pkg::FCC_YUY2, '1, '1);
    send_request(vplc_pkg::FCC_YUY2, '0, '1);
    send_request(vplc_pkg::FCC_UYVY, DIM_BITS'(1), DIM_BITS'(1));
    send_request(vplc_pkg::FCC_RGBX, '1, '1);
    send_request(vplc_pkg::FCC_RGBA, DIM_BITS'(1), '0);
    send_request(vplc_pkg::FCC_BGRX, DIM_BITS'(640), DIM_BITS'(480));
    send_request(vplc_pkg::FCC_BGRA, '1, DIM_BITS'(3));
    send_request(32'h0000_0000, '1, '1);
    send_request(32'hFFFF_FFFF, '1, '1);
    send_request(vplc_pkg::FCC_NV12 ^ 32'h0000_0020, DIM_BITS'(64), DIM_BITS'(64));
    in_ch.valid <= 1'b0;
    wait_drained();

    // Random traffic with idling on both sides.
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    repeat (RANDOM_ITEMS * 2 / 5) send_random_request();

    // Long receiver hold-off while the sender keeps offering.
    src_idle  = 1'b0;
    stall_req = 1'b1;
    repeat (40) send_random_request();

    // Back-to-back stretch with no idling.
    sink_idle = 1'b0;
    repeat (RANDOM_ITEMS / 5) send_random_request();

    // Sender pauses until every result has come back.
    in_ch.valid <= 1'b0;
    wait_drained();
    @(posedge clk);

    src_idle  = 1'b1;
    sink_idle = 1'b1;
    repeat (RANDOM_ITEMS - RANDOM_ITEMS * 2 / 5 - 40 - RANDOM_ITEMS / 5)
      send_random_request();
    in_ch.valid <= 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d frame requests (%0d with unsupported codes), checked %0d layouts",
             sent_count, unknown_count, layout_sb.checked);
    $display("Traffic mixed random gaps, back-to-back runs and a %0d-cycle output hold-off",
             STALL_CYCLES);
    if (layout_sb.mismatches == 0 && layout_sb.unexpected == 0 &&
        layout_sb.expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatched and %0d unexpected results",
               layout_sb.mismatches, layout_sb.unexpected);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
